FILE: sv/tlsrht_pkg.sv
// Package for the TLS record header tracker.
// Holds the transfer payload types, content type codes and header field positions.
// No dependencies.
`timescale 1ns / 1ps

package tlsrht_pkg;

    localparam logic [7:0] CT_CCS   = 8'h14;
    localparam logic [7:0] CT_ALERT = 8'h15;
    localparam logic [7:0] CT_HS    = 8'h16;
    localparam logic [7:0] CT_APP   = 8'h17;

    localparam logic [2:0] FP_TYPE   = 3'd0;
    localparam logic [2:0] FP_VER_HI = 3'd1;
    localparam logic [2:0] FP_VER_LO = 3'd2;
    localparam logic [2:0] FP_LEN_HI = 3'd3;
    localparam logic [2:0] FP_LEN_LO = 3'd4;

    typedef struct packed {
        logic       direction;
        logic [7:0] data_byte;
        logic       segment_end;
    } in_item_t;

    typedef struct packed {
        logic        header_complete;
        logic [7:0]  record_type;
        logic        type_valid;
        logic [15:0] record_version;
        logic [15:0] header_length;
        logic        in_body;
        logic        client_ccs_seen;
        logic        server_ccs_seen;
        logic        direction_done;
        logic        no_inspection;
        logic        no_reassembly;
    } result_t;

endpackage

FILE: sv/tlsrht_in_stage.sv
// Input register of the TLS record header tracker.
// Holds one accepted byte until the framer consumes it; uses tlsrht_pkg.
`timescale 1ns / 1ps

module tlsrht_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tlsrht_pkg::in_item_t s_item,
    input  logic               advance,
    output logic               item_valid,
    output tlsrht_pkg::in_item_t item
);

    logic                 valid_reg;
    tlsrht_pkg::in_item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

FILE: sv/tlsrht_framer.sv
// Per-direction record framing state and flow flags of the TLS record header tracker.
// Updates the state for one byte per cycle while advance is high and forms its result; uses tlsrht_pkg.
`timescale 1ns / 1ps

module tlsrht_framer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 no_reassembly_enable,
    input  logic                 advance,
    input  tlsrht_pkg::in_item_t item,
    output tlsrht_pkg::result_t  result
);

    logic [2:0]  fpos_reg    [2];
    logic [2:0]  fpos_next   [2];
    logic [15:0] remain_reg  [2];
    logic [15:0] remain_next [2];
    logic [7:0]  partial_reg [2];
    logic [7:0]  partial_next[2];
    logic [7:0]  ctype_reg   [2];
    logic [7:0]  ctype_next  [2];
    logic [15:0] version_reg [2];
    logic [15:0] version_next[2];
    logic [15:0] length_reg  [2];
    logic [15:0] length_next [2];
    logic [1:0]  type_ok_reg;
    logic [1:0]  type_ok_next;
    logic [1:0]  ccs_reg;
    logic [1:0]  ccs_next;
    logic [1:0]  done_reg;
    logic [1:0]  done_next;
    logic        insp_off_reg;
    logic        insp_off_next;
    logic        reasm_off_reg;
    logic        reasm_off_next;

    logic       d;
    logic [7:0] b;
    logic       hdr_done;
    logic       body;
    logic       type_ok;

    always_comb begin
        d              = item.direction;
        b              = item.data_byte;
        fpos_next      = fpos_reg;
        remain_next    = remain_reg;
        partial_next   = partial_reg;
        ctype_next     = ctype_reg;
        version_next   = version_reg;
        length_next    = length_reg;
        type_ok_next   = type_ok_reg;
        ccs_next       = ccs_reg;
        done_next      = done_reg;
        insp_off_next  = insp_off_reg;
        reasm_off_next = reasm_off_reg;
        hdr_done       = 1'b0;
        body           = 1'b0;
        type_ok        = (b >= tlsrht_pkg::CT_CCS) && (b <= tlsrht_pkg::CT_APP);

        if (remain_reg[d] != 16'd0) begin
            body           = 1'b1;
            remain_next[d] = remain_reg[d] - 16'd1;
        end else begin
            unique case (fpos_reg[d])
                tlsrht_pkg::FP_VER_HI: begin
                    partial_next[d] = b;
                    fpos_next[d]    = tlsrht_pkg::FP_VER_LO;
                end
                tlsrht_pkg::FP_VER_LO: begin
                    version_next[d] = {partial_reg[d], b};
                    fpos_next[d]    = tlsrht_pkg::FP_LEN_HI;
                end
                tlsrht_pkg::FP_LEN_HI: begin
                    partial_next[d] = b;
                    fpos_next[d]    = tlsrht_pkg::FP_LEN_LO;
                end
                tlsrht_pkg::FP_LEN_LO: begin
                    length_next[d] = {partial_reg[d], b};
                    remain_next[d] = {partial_reg[d], b};
                    fpos_next[d]   = tlsrht_pkg::FP_TYPE;
                    hdr_done       = 1'b1;
                end
                default: begin
                    fpos_next[d]    = tlsrht_pkg::FP_VER_HI;
                    type_ok_next[d] = type_ok;
                    if (type_ok) begin
                        ctype_next[d] = b;
                        if (!d) begin
                            if (b == tlsrht_pkg::CT_APP && ccs_reg == 2'b11) begin
                                done_next[0]  = 1'b1;
                                insp_off_next = 1'b1;
                                if (no_reassembly_enable) begin
                                    reasm_off_next = 1'b1;
                                end
                            end
                            if (b == tlsrht_pkg::CT_CCS) begin
                                ccs_next[0] = 1'b1;
                            end
                        end else begin
                            // The server completion check looks at the client's stored type.
                            if (b == tlsrht_pkg::CT_CCS) begin
                                done_next[1] = 1'b1;
                                ccs_next[1]  = 1'b1;
                            end
                            if (ctype_reg[0] == tlsrht_pkg::CT_APP && ccs_next == 2'b11) begin
                                done_next[1]  = 1'b1;
                                insp_off_next = 1'b1;
                                if (no_reassembly_enable) begin
                                    reasm_off_next = 1'b1;
                                end
                            end
                        end
                    end
                end
            endcase
        end

        if (item.segment_end) begin
            remain_next[d] = 16'd0;
        end

        result.header_complete = hdr_done;
        result.record_type     = ctype_next[d];
        result.type_valid      = type_ok_next[d];
        result.record_version  = version_next[d];
        result.header_length   = length_next[d];
        result.in_body         = body;
        result.client_ccs_seen = ccs_next[0];
        result.server_ccs_seen = ccs_next[1];
        result.direction_done  = done_next[d];
        result.no_inspection   = insp_off_next;
        result.no_reassembly   = reasm_off_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 2; i++) begin
                fpos_reg[i]    <= tlsrht_pkg::FP_TYPE;
                remain_reg[i]  <= 16'd0;
                partial_reg[i] <= 8'd0;
                ctype_reg[i]   <= 8'd0;
                version_reg[i] <= 16'd0;
                length_reg[i]  <= 16'd0;
            end
            type_ok_reg   <= 2'b00;
            ccs_reg       <= 2'b00;
            done_reg      <= 2'b00;
            insp_off_reg  <= 1'b0;
            reasm_off_reg <= 1'b0;
        end else if (advance) begin
            fpos_reg      <= fpos_next;
            remain_reg    <= remain_next;
            partial_reg   <= partial_next;
            ctype_reg     <= ctype_next;
            version_reg   <= version_next;
            length_reg    <= length_next;
            type_ok_reg   <= type_ok_next;
            ccs_reg       <= ccs_next;
            done_reg      <= done_next;
            insp_off_reg  <= insp_off_next;
            reasm_off_reg <= reasm_off_next;
        end
    end

endmodule

FILE: sv/tlsrht_out_stage.sv
// Result register of the TLS record header tracker.
// Holds one result until the downstream side takes the transfer; uses tlsrht_pkg.
`timescale 1ns / 1ps

module tlsrht_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    input  tlsrht_pkg::result_t result,
    output logic                advance,
    output logic                m_valid,
    input  logic                m_ready,
    output tlsrht_pkg::result_t m_result
);

    logic                valid_reg;
    tlsrht_pkg::result_t result_reg;

    assign advance  = item_valid && (!valid_reg || m_ready);
    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

endmodule

FILE: sv/tls_record_handshake_tracker_unit.sv
// Top level of the TLS record header tracker.
// Instantiates tlsrht_in_stage, tlsrht_framer and tlsrht_out_stage; uses tlsrht_pkg.
//
//   Channel   Direction  Handshake             Payload
//   s_        in         s_valid / s_ready     direction, data_byte, segment_end
//   m_        out        m_valid / m_ready     header_complete ... no_reassembly
//   cfg_      in         cfg_valid / cfg_ready no_reassembly_enable
//
// One byte is taken per cycle while results are taken; its result passes the input register
// and then the result register before it is offered.
// The throughput is set by the single framer update between the input and result registers.
// A synchronous reset clears all framing state and sets no_reassembly_enable.
// When the result register is full and not taken, the framer holds and s_ready drops
// only once the input register is also full.
`timescale 1ns / 1ps

module tls_record_handshake_tracker_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_direction,
    input  logic [7:0]  s_data_byte,
    input  logic        s_segment_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_header_complete,
    output logic [7:0]  m_record_type,
    output logic        m_type_valid,
    output logic [15:0] m_record_version,
    output logic [15:0] m_header_length,
    output logic        m_in_body,
    output logic        m_client_ccs_seen,
    output logic        m_server_ccs_seen,
    output logic        m_direction_done,
    output logic        m_no_inspection,
    output logic        m_no_reassembly,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_no_reassembly_enable
);

    tlsrht_pkg::in_item_t s_item;
    tlsrht_pkg::in_item_t item;
    tlsrht_pkg::result_t  result;
    tlsrht_pkg::result_t  m_result;
    logic                 item_valid;
    logic                 advance;
    logic                 nr_enable_reg;

    assign s_item.direction   = s_direction;
    assign s_item.data_byte   = s_data_byte;
    assign s_item.segment_end = s_segment_end;
    assign cfg_ready          = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nr_enable_reg <= 1'b1;
        end else if (cfg_valid) begin
            nr_enable_reg <= cfg_no_reassembly_enable;
        end
    end

    tlsrht_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    tlsrht_framer u_framer (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .no_reassembly_enable (nr_enable_reg),
        .advance              (advance),
        .item                 (item),
        .result               (result)
    );

    tlsrht_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_result   (m_result)
    );

    assign m_header_complete = m_result.header_complete;
    assign m_record_type     = m_result.record_type;
    assign m_type_valid      = m_result.type_valid;
    assign m_record_version  = m_result.record_version;
    assign m_header_length   = m_result.header_length;
    assign m_in_body         = m_result.in_body;
    assign m_client_ccs_seen = m_result.client_ccs_seen;
    assign m_server_ccs_seen = m_result.server_ccs_seen;
    assign m_direction_done  = m_result.direction_done;
    assign m_no_inspection   = m_result.no_inspection;
    assign m_no_reassembly   = m_result.no_reassembly;

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for tls_record_handshake_tracker_unit.
// Streams tagged TLS bytes through the block, predicts every result in-line and
// compares each result transfer against the oldest prediction. Depends on tlsrht_pkg.
`timescale 1ns / 1ps

module tb;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned HOLD_AT      = 300;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned TAIL_CYCLES  = 8;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_direction = 1'b0;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_segment_end = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_header_complete;
    logic [7:0]  m_record_type;
    logic        m_type_valid;
    logic [15:0] m_record_version;
    logic [15:0] m_header_length;
    logic        m_in_body;
    logic        m_client_ccs_seen;
    logic        m_server_ccs_seen;
    logic        m_direction_done;
    logic        m_no_inspection;
    logic        m_no_reassembly;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_no_reassembly_enable = 1'b0;

    tls_record_handshake_tracker_unit dut (
        .aclk                     (aclk),
        .aresetn                  (aresetn),
        .s_valid                  (s_valid),
        .s_ready                  (s_ready),
        .s_direction              (s_direction),
        .s_data_byte              (s_data_byte),
        .s_segment_end            (s_segment_end),
        .m_valid                  (m_valid),
        .m_ready                  (m_ready),
        .m_header_complete        (m_header_complete),
        .m_record_type            (m_record_type),
        .m_type_valid             (m_type_valid),
        .m_record_version         (m_record_version),
        .m_header_length          (m_header_length),
        .m_in_body                (m_in_body),
        .m_client_ccs_seen        (m_client_ccs_seen),
        .m_server_ccs_seen        (m_server_ccs_seen),
        .m_direction_done         (m_direction_done),
        .m_no_inspection          (m_no_inspection),
        .m_no_reassembly          (m_no_reassembly),
        .cfg_valid                (cfg_valid),
        .cfg_ready                (cfg_ready),
        .cfg_no_reassembly_enable (cfg_no_reassembly_enable)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    tlsrht_pkg::in_item_t pending_bytes[$];
    tlsrht_pkg::in_item_t client_stage[$];
    tlsrht_pkg::in_item_t server_stage[$];
    tlsrht_pkg::result_t  expected_results[$];
    tlsrht_pkg::result_t  seen_result;

    logic [2:0]  fpos[2];
    logic [15:0] body_left[2];
    logic [7:0]  high_hold[2];
    logic [7:0]  type_store[2];
    logic [15:0] ver_store[2];
    logic [15:0] len_store[2];
    logic        type_good[2];
    logic [1:0]  ccs_bits;
    logic [1:0]  done_bits;
    logic        insp_off;
    logic        reasm_off;
    logic        reasm_enable;

    int unsigned fault_count = 0;
    int unsigned queued_items = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_count = 0;
    logic        idle_on = 1'b1;

    assign seen_result = {m_header_complete, m_record_type, m_type_valid, m_record_version,
                          m_header_length, m_in_body, m_client_ccs_seen, m_server_ccs_seen,
                          m_direction_done, m_no_inspection, m_no_reassembly};

    initial begin
        for (int d = 0; d < 2; d++) begin
            fpos[d] = tlsrht_pkg::FP_TYPE;
            body_left[d] = '0;
            high_hold[d] = '0;
            type_store[d] = '0;
            ver_store[d] = '0;
            len_store[d] = '0;
            type_good[d] = 1'b0;
        end
        ccs_bits = '0;
        done_bits = '0;
        insp_off = 1'b0;
        reasm_off = 1'b0;
        reasm_enable = 1'b1;
    end

    task automatic finish_handshake(input int d);
        done_bits[d] = 1'b1;
        insp_off = 1'b1;
        if (reasm_enable) begin
            reasm_off = 1'b1;
        end
    endtask

    task automatic track_byte(input tlsrht_pkg::in_item_t it, output tlsrht_pkg::result_t res);
        int         d;
        logic [7:0] b;
        logic       hdr_done;
        logic       body;
        d = it.direction;
        b = it.data_byte;
        hdr_done = 1'b0;
        body = 1'b0;
        if (body_left[d] != 16'd0) begin
            body = 1'b1;
            body_left[d] = body_left[d] - 16'd1;
        end else begin
            case (fpos[d])
                tlsrht_pkg::FP_VER_HI: begin
                    high_hold[d] = b;
                    fpos[d] = tlsrht_pkg::FP_VER_LO;
                end
                tlsrht_pkg::FP_VER_LO: begin
                    ver_store[d] = {high_hold[d], b};
                    fpos[d] = tlsrht_pkg::FP_LEN_HI;
                end
                tlsrht_pkg::FP_LEN_HI: begin
                    high_hold[d] = b;
                    fpos[d] = tlsrht_pkg::FP_LEN_LO;
                end
                tlsrht_pkg::FP_LEN_LO: begin
                    len_store[d] = {high_hold[d], b};
                    body_left[d] = len_store[d];
                    fpos[d] = tlsrht_pkg::FP_TYPE;
                    hdr_done = 1'b1;
                end
                default: begin
                    type_good[d] = (b >= tlsrht_pkg::CT_CCS) && (b <= tlsrht_pkg::CT_APP);
                    if (type_good[d]) begin
                        type_store[d] = b;
                        if (d == 0) begin
                            if (b == tlsrht_pkg::CT_APP && ccs_bits == 2'b11) begin
                                finish_handshake(0);
                            end
                            if (b == tlsrht_pkg::CT_CCS) begin
                                ccs_bits[0] = 1'b1;
                            end
                        end else begin
                            if (b == tlsrht_pkg::CT_CCS) begin
                                done_bits[1] = 1'b1;
                                ccs_bits[1] = 1'b1;
                            end
                            if (type_store[0] == tlsrht_pkg::CT_APP && ccs_bits == 2'b11) begin
                                finish_handshake(1);
                            end
                        end
                    end
                    fpos[d] = tlsrht_pkg::FP_VER_HI;
                end
            endcase
        end
        if (it.segment_end) begin
            body_left[d] = '0;
        end
        res.header_complete = hdr_done;
        res.record_type = type_store[d];
        res.type_valid = type_good[d];
        res.record_version = ver_store[d];
        res.header_length = len_store[d];
        res.in_body = body;
        res.client_ccs_seen = ccs_bits[0];
        res.server_ccs_seen = ccs_bits[1];
        res.direction_done = done_bits[d];
        res.no_inspection = insp_off;
        res.no_reassembly = reasm_off;
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic log_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    // Driver: one byte transfer per handshake, fed from pending_bytes.
    tlsrht_pkg::in_item_t cur_item;
    tlsrht_pkg::result_t  predicted;
    int unsigned          send_gap = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                track_byte(cur_item, predicted);
                expected_results.push_back(predicted);
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    cur_item = pending_bytes.pop_front();
                    s_direction <= cur_item.direction;
                    s_data_byte <= cur_item.data_byte;
                    s_segment_end <= cur_item.segment_end;
                    s_valid <= 1'b1;
                    send_gap = idle_on ? pick_gap() : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold, counted here while the sender keeps offering transfers.
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
    end

    // Monitor: checks each result transfer and paces m_ready.
    tlsrht_pkg::result_t want;
    int unsigned         recv_gap = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    log_fault("Result transfer arrived with no prediction pending.");
                end else begin
                    want = expected_results.pop_front();
                    if (seen_result !== want) begin
                        log_fault($sformatf({"Mismatch on result %0d: expected hc=%b type=%h ",
                            "tv=%b ver=%h len=%h body=%b ccs=%b%b done=%b ni=%b nr=%b, actual ",
                            "hc=%b type=%h tv=%b ver=%h len=%h body=%b ccs=%b%b done=%b ni=%b ",
                            "nr=%b"}, results_seen,
                            want.header_complete, want.record_type, want.type_valid,
                            want.record_version, want.header_length, want.in_body,
                            want.client_ccs_seen, want.server_ccs_seen, want.direction_done,
                            want.no_inspection, want.no_reassembly,
                            seen_result.header_complete, seen_result.record_type,
                            seen_result.type_valid, seen_result.record_version,
                            seen_result.header_length, seen_result.in_body,
                            seen_result.client_ccs_seen, seen_result.server_ccs_seen,
                            seen_result.direction_done, seen_result.no_inspection,
                            seen_result.no_reassembly));
                    end
                end
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                recv_gap = idle_on ? pick_gap() : 0;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic queue_byte(input logic dir, input logic [7:0] b, input logic seg);
        tlsrht_pkg::in_item_t it;
        it.direction = dir;
        it.data_byte = b;
        it.segment_end = seg;
        pending_bytes.push_back(it);
        queued_items++;
    endtask

    task automatic stage_record(input logic dir);
        logic [7:0]           rec[$];
        logic [7:0]           ctype;
        logic [15:0]          ver;
        logic [15:0]          len;
        int unsigned          r;
        int unsigned          body_bytes;
        int                   seg_at;
        tlsrht_pkg::in_item_t it;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            ctype = 8'($urandom_range(0, 255));
            if (ctype >= tlsrht_pkg::CT_CCS && ctype <= tlsrht_pkg::CT_APP) begin
                ctype = ctype ^ 8'h80;
            end
        end else if (r < 45) begin
            ctype = tlsrht_pkg::CT_HS;
        end else if (r < 80) begin
            ctype = tlsrht_pkg::CT_APP;
        end else if (r < 90) begin
            ctype = tlsrht_pkg::CT_ALERT;
        end else begin
            ctype = tlsrht_pkg::CT_CCS;
        end
        ver = ($urandom_range(0, 99) < 80) ? {8'h03, 8'($urandom_range(0, 4))}
                                            : 16'($urandom_range(0, 65535));
        r = $urandom_range(0, 99);
        if (r < 70) begin
            len = 16'($urandom_range(0, 6));
        end else if (r < 95) begin
            len = 16'($urandom_range(7, 40));
        end else begin
            len = 16'($urandom_range(41, 65535));
        end
        rec.push_back(ctype);
        rec.push_back(ver[15:8]);
        rec.push_back(ver[7:0]);
        rec.push_back(len[15:8]);
        rec.push_back(len[7:0]);
        body_bytes = (len > 40) ? $urandom_range(1, 12) : len;
        for (int k = 0; k < body_bytes; k++) begin
            rec.push_back(8'($urandom_range(0, 255)));
        end
        r = $urandom_range(0, 99);
        if (len > 40 || r < 50) begin
            seg_at = rec.size() - 1;
        end else if (r < 65) begin
            seg_at = $urandom_range(0, rec.size() - 1);
        end else begin
            seg_at = -1;
        end
        for (int k = 0; k < rec.size(); k++) begin
            it.direction = dir;
            it.data_byte = rec[k];
            it.segment_end = (k == seg_at);
            if (dir) begin
                server_stage.push_back(it);
            end else begin
                client_stage.push_back(it);
            end
        end
    endtask

    task automatic merge_stage();
        tlsrht_pkg::in_item_t it;
        while (client_stage.size() > 0 || server_stage.size() > 0) begin
            if (server_stage.size() == 0 ||
                (client_stage.size() > 0 && $urandom_range(0, 1) == 0)) begin
                it = client_stage.pop_front();
            end else begin
                it = server_stage.pop_front();
            end
            queue_byte(it.direction, it.data_byte, it.segment_end);
        end
    endtask

    task automatic queue_random_phase(input int unsigned count);
        int unsigned start;
        int unsigned n;
        logic        dir;
        start = queued_items;
        while (queued_items - start < count) begin
            if ($urandom_range(0, 99) < 15) begin
                n = $urandom_range(1, 8);
                dir = 1'($urandom_range(0, 1));
                for (int k = 0; k < n; k++) begin
                    queue_byte(dir, 8'($urandom_range(0, 255)), $urandom_range(0, 99) < 20);
                end
            end else begin
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++) begin
                    stage_record(1'($urandom_range(0, 1)));
                end
                merge_stage();
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || s_valid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reassembly_enable(input logic value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_no_reassembly_enable <= value;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        reasm_enable = value;
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        write_reassembly_enable(1'b0);

        // Client handshake record with zero length and a segment end on the last header byte.
        queue_byte(1'b0, tlsrht_pkg::CT_HS, 1'b0);
        queue_byte(1'b0, 8'h03, 1'b0);
        queue_byte(1'b0, 8'h01, 1'b0);
        queue_byte(1'b0, 8'h00, 1'b0);
        queue_byte(1'b0, 8'h00, 1'b1);
        // Invalid content type, with the version split across a segment end.
        queue_byte(1'b0, tlsrht_pkg::CT_CCS - 8'd1, 1'b0);
        queue_byte(1'b0, 8'hFF, 1'b1);
        queue_byte(1'b0, 8'hFF, 1'b0);
        queue_byte(1'b0, 8'h00, 1'b0);
        queue_byte(1'b0, 8'h00, 1'b0);
        // Server change cipher spec with a one-byte body.
        queue_byte(1'b1, tlsrht_pkg::CT_CCS, 1'b0);
        queue_byte(1'b1, 8'h03, 1'b0);
        queue_byte(1'b1, 8'h03, 1'b0);
        queue_byte(1'b1, 8'h00, 1'b0);
        queue_byte(1'b1, 8'h01, 1'b0);
        queue_byte(1'b1, 8'hA5, 1'b1);
        // Client change cipher spec, then application data with the largest length cut off.
        queue_byte(1'b0, tlsrht_pkg::CT_CCS, 1'b0);
        queue_byte(1'b0, 8'h03, 1'b0);
        queue_byte(1'b0, 8'h03, 1'b0);
        queue_byte(1'b0, 8'h00, 1'b0);
        queue_byte(1'b0, 8'h00, 1'b0);
        queue_byte(1'b0, tlsrht_pkg::CT_APP, 1'b0);
        queue_byte(1'b0, 8'hFE, 1'b0);
        queue_byte(1'b0, 8'hFF, 1'b0);
        queue_byte(1'b0, 8'hFF, 1'b0);
        queue_byte(1'b0, 8'hFF, 1'b1);
        // Server application data completes on the stored client type.
        queue_byte(1'b1, tlsrht_pkg::CT_APP, 1'b0);
        wait_drained();

        write_reassembly_enable(1'b1);
        queue_random_phase(600);
        wait_drained();

        write_reassembly_enable(1'b0);
        idle_on = 1'b0;
        queue_random_phase(500);
        wait_drained();
        idle_on = 1'b1;

        write_reassembly_enable(1'b1);
        queue_random_phase(550);
        wait_drained();
        fault_count += expected_results.size();

        if (fault_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
